// File: design/qsma_pkg.sv
// Types and constants for the qualified sensor moving average.
// Shared by the controller, datapath, divider and top level.
package qsma_pkg;

  localparam int unsigned HUM_MAX = 1000;
  localparam int unsigned TEMP_LIM = 32767;
  localparam int unsigned RUN_MAX = 255;
  localparam int unsigned NUM_W = 28;
  localparam int unsigned DEN_W = 18;

  typedef enum logic [2:0] {
    CFG_FAULT_STRIKES   = 3'd0,
    CFG_RECOVER_STRIKES = 3'd1,
    CFG_TEMP_MIN        = 3'd2,
    CFG_TEMP_MAX        = 3'd3,
    CFG_TEMP_STEP       = 3'd4,
    CFG_HUM_STEP        = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              read_ok;
    logic signed [15:0] temp_in;
    logic [15:0]       humidity_in;
  } in_item_t;

  typedef struct packed {
    logic              valid_out;
    logic signed [15:0] temp_out;
    logic [9:0]        humidity_out;
  } out_item_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_QUAL  = 6'b000010,
    ST_SUM   = 6'b000100,
    ST_DIVT  = 6'b001000,
    ST_DIVH  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic qual;
    logic sum_clr;
    logic sum_step;
    logic divt_start;
    logic divh_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic accept;
    logic sum_last;
    logic div_done;
  } sts_t;

endpackage

// File: design/qualified_sensor_moving_average.sv
// Top level of the qualified sensor moving average filter.
// Joins qsma_ctrl and qsma_dp; uses qsma_pkg payload types.
//
// One item at a time: a read that enters the window goes through qualify, the
// one-entry-a-cycle window sweep, a run of the bit-serial divider for
// temperature and then one for humidity, the result load and the take of the
// next read. A read that does not enter the window goes from qualify straight
// to the result load. The result sits in an output register and holds until
// transferred; a new read is taken once its result is loaded there.
module qualified_sensor_moving_average
  import qsma_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);
  cmd_t cmd;
  sts_t sts;

  qsma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  qsma_dp #(.WINDOW_SIZE(WINDOW_SIZE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );
endmodule

// File: design/qsma_div.sv
// Restoring divider with half-away-from-zero rounding, one bit a cycle.
// Uses qsma_pkg widths.
module qsma_div
  import qsma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num_mag,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int unsigned CW = $clog2(NUM_W + 2);
  localparam int unsigned DW = NUM_W + 1;
  localparam int unsigned RW = DEN_W + 2;
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic [DW-1:0] n_r, n_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] d2_r, d2_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [RW-1:0] sh;

  assign sh = {rem_r[RW-2:0], n_r[DW-1]};

  always_comb begin
    n_nxt = n_r;
    rem_nxt = rem_r;
    d2_nxt = d2_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt = {num_mag, 1'b0} + DW'(den);
      rem_nxt = '0;
      d2_nxt = {1'b0, den, 1'b0};
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[DW-2:0], 1'b0};
      if (sh >= d2_r) begin
        rem_nxt = sh - d2_r;
        n_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt;
    rem_r <= rem_nxt;
    d2_r <= d2_nxt;
  end

  assign done = done_r;
  assign quot = n_r[NUM_W-1:0];
endmodule

// File: design/qsma_ctrl.sv
// Controller state machine for the qualified sensor moving average.
// Uses qsma_pkg state, command and status types.
module qsma_ctrl
  import qsma_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_QUAL;
        end
      end
      ST_QUAL: begin
        cmd.qual = 1'b1;
        cmd.sum_clr = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (!sts.accept) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.sum_step = 1'b1;
          if (sts.sum_last) begin
            cmd.divt_start = 1'b1;
            state_nxt = ST_DIVT;
          end
        end
      end
      ST_DIVT: begin
        if (sts.div_done) begin
          cmd.divh_start = 1'b1;
          state_nxt = ST_DIVH;
        end
      end
      ST_DIVH: begin
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = ov_r;
endmodule

// File: design/qsma_dp.sv
// Datapath: qualification, streak counters, window store, sums and rounding.
// Uses qsma_pkg and the qsma_div divider.
module qsma_dp
  import qsma_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  in_item_t    in_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_item_t   out_data
);
  localparam int unsigned AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned FW = $clog2(WINDOW_SIZE + 1);
  localparam logic [FW-1:0] FMAX = FW'(WINDOW_SIZE);

  logic [7:0]        fstr_r, rstr_r;
  logic signed [15:0] tmin_r, tmax_r;
  logic [9:0]        tstep_r, hstep_r;

  in_item_t          it_r;
  logic [7:0]        frun_r, grun_r;
  logic              sval_r, have_r, acc_r;
  logic [FW-1:0]     fill_r;
  logic [AW-1:0]     slot_r, idx_r;
  logic signed [15:0] avgt_r;
  logic [9:0]        avgh_r;
  logic signed [NUM_W-1:0] tsum_r;
  logic [NUM_W-1:0]  hsum_r;
  logic signed [15:0] tmem [WINDOW_SIZE];
  logic [9:0]        hmem [WINDOW_SIZE];
  logic signed [15:0] trd_r;
  logic [9:0]        hrd_r;
  logic              rdv_r, lastrd_r;
  out_item_t         out_r;

  logic              good;
  logic [7:0]        frun_inc, grun_inc;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  num_mag, quot;
  logic [DEN_W-1:0]  den;
  logic [9:0]        step_sel;
  logic [DEN_W-1:0]  tden_r, hden_r;
  logic              tneg_r;
  logic signed [NUM_W+10:0] tq;
  logic [NUM_W+10:0] hq;
  logic              tq_ld, hq_ld, phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstr_r <= 8'd3;
      rstr_r <= 8'd3;
      tmin_r <= -16'sd400;
      tmax_r <= 16'sd800;
      tstep_r <= 10'd1;
      hstep_r <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAULT_STRIKES:   fstr_r <= cfg_wdata[7:0];
        CFG_RECOVER_STRIKES: rstr_r <= cfg_wdata[7:0];
        CFG_TEMP_MIN:        tmin_r <= cfg_wdata;
        CFG_TEMP_MAX:        tmax_r <= cfg_wdata;
        CFG_TEMP_STEP:       tstep_r <= cfg_wdata[9:0];
        CFG_HUM_STEP:        hstep_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign good = it_r.read_ok && (it_r.temp_in >= tmin_r) && (it_r.temp_in <= tmax_r)
                && (it_r.humidity_in <= 16'(HUM_MAX));
  assign frun_inc = (frun_r == 8'(RUN_MAX)) ? frun_r : frun_r + 8'd1;
  assign grun_inc = (grun_r == 8'(RUN_MAX)) ? grun_r : grun_r + 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frun_r <= '0;
      grun_r <= '0;
      sval_r <= 1'b0;
      have_r <= 1'b0;
      fill_r <= '0;
      slot_r <= '0;
      acc_r <= 1'b0;
      avgt_r <= '0;
      avgh_r <= '0;
    end else begin
      if (cmd.qual) begin
        acc_r <= 1'b0;
        if (!good) begin
          frun_r <= frun_inc;
          grun_r <= '0;
          if (frun_inc >= fstr_r) begin
            sval_r <= 1'b0;
            have_r <= 1'b0;
            fill_r <= '0;
            slot_r <= '0;
          end
        end else begin
          frun_r <= '0;
          grun_r <= grun_inc;
          if (sval_r || grun_inc >= rstr_r) begin
            logic [AW-1:0] s;
            logic [FW-1:0] f;
            s = sval_r ? slot_r : '0;
            f = sval_r ? fill_r : '0;
            sval_r <= 1'b1;
            acc_r <= 1'b1;
            slot_r <= (32'(s) == WINDOW_SIZE - 1) ? '0 : s + 1'b1;
            fill_r <= (f == FMAX) ? f : f + 1'b1;
          end
        end
      end
      if (cmd.out_load && acc_r) have_r <= 1'b1;
      if (tq_ld) begin
        if (tq > (NUM_W+11)'(signed'(TEMP_LIM))) avgt_r <= 16'(TEMP_LIM);
        else if (tq < -(NUM_W+11)'(signed'(TEMP_LIM))) avgt_r <= -16'(TEMP_LIM);
        else avgt_r <= tq[15:0];
      end
      if (hq_ld) begin
        if (hq > (NUM_W+11)'(HUM_MAX)) avgh_r <= 10'(HUM_MAX);
        else avgh_r <= hq[9:0];
      end
    end
  end

  // window write at the slot chosen in qualify
  logic [AW-1:0] wslot;
  assign wslot = sval_r ? slot_r : '0;
  always_ff @(posedge clk) begin
    if (cmd.qual && good && (sval_r || grun_inc >= rstr_r)) begin
      tmem[wslot] <= it_r.temp_in;
      hmem[wslot] <= it_r.humidity_in[9:0];
    end
    trd_r <= tmem[idx_r];
    hrd_r <= hmem[idx_r];
  end

  // read address sweep, one entry a cycle, accumulate registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      rdv_r <= 1'b0;
      lastrd_r <= 1'b0;
    end else begin
      if (cmd.sum_clr) begin
        idx_r <= '0;
        rdv_r <= 1'b0;
        lastrd_r <= 1'b0;
      end else if (acc_r && !lastrd_r) begin
        rdv_r <= 1'b1;
        lastrd_r <= (FW'(idx_r) + 1'b1 == fill_r);
        if (FW'(idx_r) + 1'b1 != fill_r) idx_r <= idx_r + 1'b1;
      end else begin
        rdv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      tsum_r <= '0;
      hsum_r <= '0;
    end else if (rdv_r) begin
      tsum_r <= tsum_r + NUM_W'(trd_r);
      hsum_r <= hsum_r + NUM_W'(hrd_r);
    end
  end

  logic rdv_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rdv_d_r <= 1'b0;
    else rdv_d_r <= cmd.sum_clr ? 1'b0 : (lastrd_r && rdv_r);
  end
  assign sts.accept = acc_r;
  assign sts.sum_last = rdv_d_r;

  // divide: temperature first, then humidity
  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= 1'b0;
    else if (cmd.divt_start) phase_r <= 1'b0;
    else if (cmd.divh_start) phase_r <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (cmd.divt_start) begin
      tneg_r <= tsum_r < 0;
      tden_r <= (tstep_r == '0) ? DEN_W'(fill_r) : DEN_W'(fill_r) * DEN_W'(tstep_r);
      hden_r <= (hstep_r == '0) ? DEN_W'(fill_r) : DEN_W'(fill_r) * DEN_W'(hstep_r);
    end
  end
  logic dstart_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dstart_r <= 1'b0;
    else dstart_r <= cmd.divt_start || cmd.divh_start;
  end
  assign div_start = dstart_r;
  assign step_sel = phase_r ? hstep_r : tstep_r;
  assign den = phase_r ? hden_r : tden_r;
  assign num_mag = phase_r ? hsum_r : (tneg_r ? NUM_W'(-tsum_r) : NUM_W'(tsum_r));
  assign tq_ld = div_done && !phase_r;
  assign hq_ld = div_done && phase_r;
  always_comb begin
    logic [NUM_W+10:0] m;
    m = (step_sel == '0) ? (NUM_W+11)'(quot) : (NUM_W+11)'(quot) * (NUM_W+11)'(step_sel);
    tq = tneg_r ? -signed'(m) : signed'(m);
    hq = m;
  end

  qsma_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (num_mag),
    .den     (den),
    .done    (div_done),
    .quot    (quot)
  );
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sval_r && (have_r || acc_r)) begin
        out_r.valid_out <= 1'b1;
        out_r.temp_out <= avgt_r;
        out_r.humidity_out <= avgh_r;
      end else begin
        out_r <= '0;
      end
    end
  end
  assign out_data = out_r;
endmodule

// File: design/qsma_checker.sv
// Port-level checker for the qualified sensor moving average.
// Uses qsma_pkg types; bound to the top level.
module qsma_checker
  import qsma_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_zero_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_out |-> out_data.temp_out == 16'sd0
      && out_data.humidity_out == 10'd0)
    else $error("invalid result not zero");
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.humidity_out <= 10'(HUM_MAX))
    else $error("humidity out of range");
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");
endmodule

bind qualified_sensor_moving_average qsma_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/tb_qualified_sensor_moving_average.sv
// Self-checking testbench for qualified_sensor_moving_average: drives sensor reads
// over the valid/stall channel, predicts each result in a scoreboard class.
// Depends on qsma_pkg and the design top level.
module tb_qualified_sensor_moving_average;
  import qsma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 8;
  localparam int IDLE_LIMIT = 20000;

  class avg_scoreboard;
    int fault_lim, recover_lim, tmin, tmax, tstep, hstep;
    int twin[WIN];
    int hwin[WIN];
    int fill, slot, fault_run, good_run;
    bit sens_ok, have_avg;
    int avg_t, avg_h;
    out_item_t pending[$];
    int errors;

    function new();
      fault_lim = 3; recover_lim = 3; tmin = -400; tmax = 800;
      tstep = 1; hstep = 1;
      fill = 0; slot = 0; fault_run = 0; good_run = 0;
      sens_ok = 0; have_avg = 0; avg_t = 0; avg_h = 0; errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_FAULT_STRIKES:   fault_lim = v[7:0];
        CFG_RECOVER_STRIKES: recover_lim = v[7:0];
        CFG_TEMP_MIN:        tmin = $signed(v);
        CFG_TEMP_MAX:        tmax = $signed(v);
        CFG_TEMP_STEP:       tstep = v[9:0];
        CFG_HUM_STEP:        hstep = v[9:0];
        default: ;
      endcase
    endfunction

    function longint round_div(longint num, longint den);
      longint mag, q;
      mag = num < 0 ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return num < 0 ? -q : q;
    endfunction

    function longint quantize(longint s, int cnt, int stp);
      if (stp == 0) return round_div(s, cnt);
      return round_div(s, longint'(cnt) * stp) * stp;
    endfunction

    function void note_read(in_item_t it);
      int t, h;
      bit good, take;
      longint ts, hs, q;
      out_item_t e;
      t = it.temp_in;
      h = it.humidity_in;
      good = it.read_ok && t >= tmin && t <= tmax && h <= HUM_MAX;
      if (!good) begin
        if (fault_run < RUN_MAX) fault_run++;
        good_run = 0;
        if (fault_run >= fault_lim) begin
          sens_ok = 0; have_avg = 0; fill = 0; slot = 0;
        end
      end else begin
        take = 1;
        fault_run = 0;
        if (good_run < RUN_MAX) good_run++;
        if (!sens_ok) begin
          if (good_run < recover_lim) take = 0;
          else begin
            sens_ok = 1; have_avg = 0; fill = 0; slot = 0;
          end
        end
        if (take) begin
          twin[slot] = t;
          hwin[slot] = h;
          slot = (slot + 1) % WIN;
          if (fill < WIN) fill++;
          ts = 0; hs = 0;
          for (int i = 0; i < fill; i++) begin
            ts += twin[i];
            hs += hwin[i];
          end
          q = quantize(ts, fill, tstep);
          if (q > longint'(TEMP_LIM)) q = TEMP_LIM;
          if (q < -longint'(TEMP_LIM)) q = -longint'(TEMP_LIM);
          avg_t = int'(q);
          q = quantize(hs, fill, hstep);
          if (q > HUM_MAX) q = HUM_MAX;
          if (q < 0) q = 0;
          avg_h = int'(q);
          have_avg = fill > 0;
        end
      end
      e = '0;
      if (sens_ok && have_avg) begin
        e.valid_out = 1'b1;
        e.temp_out = avg_t[15:0];
        e.humidity_out = avg_h[9:0];
      end
      pending.push_back(e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.valid_out !== e.valid_out)
        begin $display("%0t: valid exp %0d got %0d", $time, e.valid_out, got.valid_out); errors++; end
      if (got.temp_out !== e.temp_out)
        begin $display("%0t: temp exp %0d got %0d", $time, e.temp_out, got.temp_out); errors++; end
      if (got.humidity_out !== e.humidity_out)
        begin $display("%0t: hum exp %0d got %0d", $time, e.humidity_out, got.humidity_out); errors++; end
    endfunction
  endclass

  logic clk, rst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
  logic [2:0] cfg_index;
  logic [15:0] cfg_wdata;
  in_item_t in_data;
  out_item_t out_data;

  avg_scoreboard sb;
  bit quiet;
  bit hold_off;
  int idle_cycles;

  qualified_sensor_moving_average DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_read(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 8);
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_read(bit ok, logic [15:0] t, logic [15:0] h);
    in_item_t it;
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.read_ok = ok;
    it.temp_in = t;
    it.humidity_in = h;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_read(int tlo, int thi);
    int r;
    r = $urandom_range(99);
    if (r < 80)
      send_read(1'b1, 16'($urandom_range(thi - tlo) + tlo), 16'($urandom_range(1000)));
    else if (r < 90)
      send_read(1'b0, 16'($urandom), 16'($urandom));
    else
      send_read(1'b1, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    sb = new();
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 0; in_data = '0; out_stall = 0;
    quiet = 0; hold_off = 0; idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 4; i++) send_read(1'b1, 16'd250, 16'd500);
    send_read(1'b1, 16'(-400), 16'd0);
    send_read(1'b1, 16'd800, 16'd1000);
    send_read(1'b1, 16'd801, 16'd500);
    send_read(1'b1, 16'd200, 16'd1001);
    send_read(1'b0, 16'd200, 16'd500);
    send_read(1'b1, 16'd100, 16'hFFFF);
    send_read(1'b1, 16'h8000, 16'd500);
    send_read(1'b1, 16'h7FFF, 16'd500);
    for (int i = 0; i < 4; i++) send_read(1'b1, 16'(-5 - i), 16'd5);
    for (int i = 0; i < 9; i++) send_read(1'b1, 16'(15 * i - 60), 16'(111 * i));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_FAULT_STRIKES, 16'd0); write_reg(CFG_RECOVER_STRIKES, 16'd0);
          write_reg(CFG_TEMP_MIN, 16'h8001); write_reg(CFG_TEMP_MAX, 16'h7FFF);
          write_reg(CFG_TEMP_STEP, 16'd0); write_reg(CFG_HUM_STEP, 16'd0);
        end
        1: begin
          write_reg(CFG_FAULT_STRIKES, 16'd1); write_reg(CFG_RECOVER_STRIKES, 16'd1);
          write_reg(CFG_TEMP_STEP, 16'd1000); write_reg(CFG_HUM_STEP, 16'd1000);
        end
        2: begin
          write_reg(CFG_FAULT_STRIKES, 16'd255); write_reg(CFG_RECOVER_STRIKES, 16'd255);
          write_reg(CFG_TEMP_STEP, 16'd7); write_reg(CFG_HUM_STEP, 16'd3);
        end
        3: begin
          write_reg(CFG_FAULT_STRIKES, 16'hFF02); write_reg(CFG_RECOVER_STRIKES, 16'hAA04);
          write_reg(CFG_TEMP_MIN, 16'd500); write_reg(CFG_TEMP_MAX, 16'd100);
          write_reg(CFG_TEMP_STEP, 16'hFC05); write_reg(CFG_HUM_STEP, 16'hFC0A);
        end
        4: begin
          write_reg(CFG_TEMP_MIN, 16'h8000); write_reg(CFG_TEMP_MAX, 16'hFFFF);
          write_reg(CFG_TEMP_STEP, 16'h3FF); write_reg(CFG_HUM_STEP, 16'd1);
        end
        5: begin
          write_reg(CFG_TEMP_MIN, 16'h7000); write_reg(CFG_TEMP_MAX, 16'h7FFF);
          write_reg(CFG_TEMP_STEP, 16'd1000); write_reg(CFG_HUM_STEP, 16'd999);
        end
        6: begin
          write_reg(CFG_FAULT_STRIKES, 16'd3); write_reg(CFG_RECOVER_STRIKES, 16'd2);
          write_reg(CFG_TEMP_MIN, 16'(-400)); write_reg(CFG_TEMP_MAX, 16'd800);
          write_reg(CFG_TEMP_STEP, 16'd5); write_reg(CFG_HUM_STEP, 16'd0);
        end
        default: begin
          write_reg(CFG_TEMP_STEP, 16'd1); write_reg(CFG_HUM_STEP, 16'd1);
        end
      endcase
      cfg_we <= 1'b0;
      quiet = (ph == 6);
      if (ph == 7) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
          repeat (20) random_read(-400, 800);
        join
      end
      for (int i = 0; i < 150; i++) begin
        case (ph)
          0: random_read(-32767, 32767);
          2: if (i < 60) send_read(1'b0, 16'($urandom), 16'($urandom));
             else random_read(-32767, 32767);
          4: random_read(-32767, -1);
          5: random_read(28672, 32767);
          default: random_read(-400, 800);
        endcase
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: filelist.f
design/qsma_pkg.sv
design/qsma_div.sv
design/qsma_ctrl.sv
design/qsma_dp.sv
design/qualified_sensor_moving_average.sv
design/qsma_checker.sv
test/tb_qualified_sensor_moving_average.sv
